@@ design/mfd_pkg.sv @@
// ----------------------------------------------------------------------------
// mfd_pkg
// Shared types, codes and helpers for the message frame deframer.
// ----------------------------------------------------------------------------
package mfd_pkg;

  // Default width of each field's length prefix
  localparam int LENGTH_PREFIX_BITS_DEFAULT = 32;

  // Configuration register indexes
  localparam logic REG_MAGIC   = 1'b0;
  localparam logic REG_VERSION = 1'b1;

  // Parse phases
  localparam logic [3:0] PH_MAGIC    = 4'd0;
  localparam logic [3:0] PH_VERSION  = 4'd1;
  localparam logic [3:0] PH_TYPE     = 4'd2;
  localparam logic [3:0] PH_ID       = 4'd3;
  localparam logic [3:0] PH_SRC_LEN  = 4'd4;
  localparam logic [3:0] PH_PAY_LEN  = 4'd10;
  localparam logic [3:0] PH_PAY_DATA = 4'd11;
  localparam logic [3:0] PH_DONE     = 4'd12;

  // Input actions
  localparam logic ACT_BYTE = 1'b0;
  localparam logic ACT_END  = 1'b1;

  // Result kinds
  localparam logic [2:0] KIND_TYPE = 3'd0;
  localparam logic [2:0] KIND_ID   = 3'd1;
  localparam logic [2:0] KIND_END  = 3'd6;

  // End status codes
  localparam logic [3:0] STAT_OK           = 4'd0;
  localparam logic [3:0] STAT_MISS_MAGIC   = 4'd1;
  localparam logic [3:0] STAT_BAD_MAGIC    = 4'd2;
  localparam logic [3:0] STAT_MISS_VERSION = 4'd3;
  localparam logic [3:0] STAT_BAD_VERSION  = 4'd4;
  localparam logic [3:0] STAT_MISS_TYPE    = 4'd5;
  localparam logic [3:0] STAT_MISS_ID      = 4'd6;
  localparam logic [3:0] STAT_BAD_SOURCE   = 4'd7;
  localparam logic [3:0] STAT_NONE         = 4'd0;

  // One result transaction
  typedef struct packed {
    logic [2:0]  kind;
    logic [63:0] value;
    logic        field_last;
    logic [3:0]  status;
  } mfd_result_t;

  // Status reported by the end marker for a given parse position
  function automatic logic [3:0] mfd_end_status(input logic [3:0] phase,
                                                input logic [3:0] err);
    logic [3:0] ph_off;
    logic [3:0] st;
    ph_off = phase - PH_SRC_LEN;
    st     = STAT_OK;
    if (err != STAT_NONE) begin
      st = err;
    end else begin
      case (phase)
        PH_MAGIC:   st = STAT_MISS_MAGIC;
        PH_VERSION: st = STAT_MISS_VERSION;
        PH_TYPE:    st = STAT_MISS_TYPE;
        PH_ID:      st = STAT_MISS_ID;
        default: begin
          // length prefix and body of a field share one status
          if (phase >= PH_SRC_LEN && phase <= PH_PAY_DATA) begin
            st = STAT_BAD_SOURCE + {1'b0, ph_off[3:1]};
          end
        end
      endcase
    end
    return st;
  endfunction

endpackage

@@ design/mfd_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// mfd_cfg_regs
// Configuration registers: expected magic word and expected version.
// ----------------------------------------------------------------------------
module mfd_cfg_regs
  import mfd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  output logic [31:0] expected_magic,
  output logic [15:0] expected_version
);

  // Register write decode
  always_ff @(posedge clk) begin
    if (rst) begin
      expected_magic   <= '0;
      expected_version <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_MAGIC:   expected_magic   <= cfg_data;
        REG_VERSION: expected_version <= cfg_data[15:0];
        default:     ;
      endcase
    end
  end

endmodule

@@ design/mfd_parser.sv @@
// ----------------------------------------------------------------------------
// mfd_parser
// Byte-wise frame parser: holds the parse state and forms at most one
// result for each accepted input transaction.
// ----------------------------------------------------------------------------
module mfd_parser
  import mfd_pkg::*;
#(
  parameter int LENGTH_PREFIX_BITS = LENGTH_PREFIX_BITS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        accept,
  input  logic        action,
  input  logic [7:0]  data_byte,
  input  logic [31:0] expected_magic,
  input  logic [15:0] expected_version,
  output logic        res_valid,
  output mfd_result_t res
);

  localparam int LEN_BYTES = (LENGTH_PREFIX_BITS + 7) / 8;

  logic [3:0]                    phase, phase_next;
  logic [2:0]                    byte_count, byte_count_next;
  logic [63:0]                   assembly_shift, assembly_shift_next;
  logic [LENGTH_PREFIX_BITS-1:0] bytes_remaining, bytes_remaining_next;
  logic [3:0]                    latched_error, latched_error_next;

  logic [63:0]                   shifted;
  logic [2:0]                    last_count;
  logic                          word_done;
  logic [LENGTH_PREFIX_BITS-1:0] prefix_len;

  assign shifted    = {assembly_shift[55:0], data_byte};
  assign prefix_len = shifted[LENGTH_PREFIX_BITS-1:0];

  // Byte count at which the multi-byte word in progress completes
  always_comb begin
    case (phase)
      PH_MAGIC:   last_count = 3'd3;
      PH_VERSION: last_count = 3'd1;
      PH_ID:      last_count = 3'd7;
      default:    last_count = 3'(LEN_BYTES - 1);
    endcase
  end

  assign word_done = (byte_count >= last_count);

  // Next state and result
  always_comb begin
    phase_next           = phase;
    byte_count_next      = byte_count;
    assembly_shift_next  = assembly_shift;
    bytes_remaining_next = bytes_remaining;
    latched_error_next   = latched_error;
    res_valid            = 1'b0;
    res                  = '0;

    if (accept) begin
      if (action == ACT_END) begin
        // end marker: report and start afresh
        res_valid            = 1'b1;
        res.kind             = KIND_END;
        res.status           = mfd_end_status(phase, latched_error);
        phase_next           = PH_MAGIC;
        byte_count_next      = '0;
        assembly_shift_next  = '0;
        bytes_remaining_next = '0;
        latched_error_next   = STAT_NONE;
      end else if (latched_error == STAT_NONE && phase < PH_DONE) begin
        unique case (phase)
          PH_MAGIC: begin
            assembly_shift_next = shifted;
            byte_count_next     = word_done ? 3'd0 : byte_count + 3'd1;
            if (word_done) begin
              assembly_shift_next = '0;
              if (shifted[31:0] != expected_magic) latched_error_next = STAT_BAD_MAGIC;
              else phase_next = PH_VERSION;
            end
          end
          PH_VERSION: begin
            assembly_shift_next = shifted;
            byte_count_next     = word_done ? 3'd0 : byte_count + 3'd1;
            if (word_done) begin
              assembly_shift_next = '0;
              if (shifted[15:0] != expected_version) latched_error_next = STAT_BAD_VERSION;
              else phase_next = PH_TYPE;
            end
          end
          PH_TYPE: begin
            res_valid  = 1'b1;
            res.kind   = KIND_TYPE;
            res.value  = {56'd0, data_byte};
            phase_next = PH_ID;
          end
          PH_ID: begin
            assembly_shift_next = shifted;
            byte_count_next     = word_done ? 3'd0 : byte_count + 3'd1;
            if (word_done) begin
              res_valid           = 1'b1;
              res.kind            = KIND_ID;
              res.value           = shifted;
              assembly_shift_next = '0;
              phase_next          = PH_SRC_LEN;
            end
          end
          default: begin
            if (!phase[0]) begin
              // length prefix byte
              assembly_shift_next = shifted;
              byte_count_next     = word_done ? 3'd0 : byte_count + 3'd1;
              if (word_done) begin
                assembly_shift_next  = '0;
                bytes_remaining_next = prefix_len;
                if (prefix_len != '0) phase_next = phase + 4'd1;
                else if (phase == PH_PAY_LEN) phase_next = PH_DONE;
                else phase_next = phase + 4'd2;
              end
            end else begin
              // field body byte; odd phases map straight onto kinds 2..5
              bytes_remaining_next = bytes_remaining - LENGTH_PREFIX_BITS'(1);
              res_valid            = 1'b1;
              res.kind             = phase[3:1];
              res.value            = {56'd0, data_byte};
              res.field_last       = (bytes_remaining == LENGTH_PREFIX_BITS'(1));
              if (res.field_last) begin
                phase_next = (phase == PH_PAY_DATA) ? PH_DONE : phase + 4'd1;
              end
            end
          end
        endcase
      end
    end
  end

  // Parse state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_MAGIC;
      byte_count      <= '0;
      assembly_shift  <= '0;
      bytes_remaining <= '0;
      latched_error   <= STAT_NONE;
    end else begin
      phase           <= phase_next;
      byte_count      <= byte_count_next;
      assembly_shift  <= assembly_shift_next;
      bytes_remaining <= bytes_remaining_next;
      latched_error   <= latched_error_next;
    end
  end

endmodule

@@ design/mfd_out_buf.sv @@
// ----------------------------------------------------------------------------
// mfd_out_buf
// Result register with a skid stage, so the input side keeps taking
// transactions while a result waits for the receiver.
// ----------------------------------------------------------------------------
module mfd_out_buf
  import mfd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  mfd_result_t push_data,
  output logic        can_push,
  output logic        out_valid,
  input  logic        out_ready,
  output mfd_result_t out_data
);

  logic        main_valid;
  mfd_result_t main_data;
  logic        skid_valid;
  mfd_result_t skid_data;
  logic        pop;

  assign pop       = main_valid && out_ready;
  assign out_valid = main_valid;
  assign out_data  = main_data;
  assign can_push  = !skid_valid;

  // Control: a push never coincides with a full skid stage
  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) skid_valid <= 1'b0;
    end else if (push) begin
      if (main_valid && !pop) skid_valid <= 1'b1;
      else main_valid <= 1'b1;
    end else if (pop) begin
      main_valid <= 1'b0;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) main_data <= skid_data;
    end else if (push) begin
      if (main_valid && !pop) skid_data <= push_data;
      else main_data <= push_data;
    end
  end

endmodule

@@ design/message_frame_deframer.sv @@
// ----------------------------------------------------------------------------
// message_frame_deframer
// Parses big-endian message buffers one byte per transaction: magic,
// version, type, id and four length-prefixed fields.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): action 0 carries data_byte as the
//   next buffer byte; action 1 closes the buffer and always yields one end
//   status result, after which the next byte starts a new buffer.
//   Output channel (out_valid/out_ready): kind, value, field_last, status.
//   Type, id and each field byte give one result; magic, version, length
//   prefix bytes, bytes after the payload and bytes after an error give none.
//   The parser writes each result into the result register; when the
//   receiver stalls, a skid stage holds one more result. Throughput: one
//   transaction per cycle while in_ready is high, set by the single pass of
//   the parser between the state registers and the result register. in_ready
//   drops only once both the result register and skid stage are full.
//   Configuration writes (cfg_wr_en) take effect at once; write them only
//   while the block is idle.
//   Reset clears the parse state, the buffered results and both
//   configuration registers.
// ----------------------------------------------------------------------------
module message_frame_deframer
  import mfd_pkg::*;
#(
  parameter int LENGTH_PREFIX_BITS = LENGTH_PREFIX_BITS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        action,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  kind,
  output logic [63:0] value,
  output logic        field_last,
  output logic [3:0]  status
);

  logic [31:0] expected_magic;
  logic [15:0] expected_version;
  logic        accept;
  logic        res_valid;
  mfd_result_t res;
  mfd_result_t out_data;

  assign accept = in_valid && in_ready;

  // Configuration registers
  mfd_cfg_regs u_cfg (
    .clk              (clk),
    .rst              (rst),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .expected_magic   (expected_magic),
    .expected_version (expected_version)
  );

  // Parser
  mfd_parser #(
    .LENGTH_PREFIX_BITS (LENGTH_PREFIX_BITS)
  ) u_parser (
    .clk              (clk),
    .rst              (rst),
    .accept           (accept),
    .action           (action),
    .data_byte        (data_byte),
    .expected_magic   (expected_magic),
    .expected_version (expected_version),
    .res_valid        (res_valid),
    .res              (res)
  );

  // Result register and skid stage
  mfd_out_buf u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res),
    .can_push  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign kind       = out_data.kind;
  assign value      = out_data.value;
  assign field_last = out_data.field_last;
  assign status     = out_data.status;

endmodule

@@ verif/mfd_stream_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mfd_stream_checker
// Watches the configuration port and both channels of the message frame
// deframer, predicts each result from the accepted input transactions and
// compares every accepted result, field by field, with the oldest one due.
// ----------------------------------------------------------------------------
module mfd_stream_checker
  import mfd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        action,
  input  logic [7:0]  data_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [2:0]  kind,
  input  logic [63:0] value,
  input  logic        field_last,
  input  logic [3:0]  status,
  output int          mismatches,
  output int          pending
);

  localparam int          PREFIX_BITS  = LENGTH_PREFIX_BITS_DEFAULT;
  localparam int          PREFIX_BYTES = (PREFIX_BITS + 7) / 8;
  localparam logic [63:0] PREFIX_MASK  = (64'd1 << PREFIX_BITS) - 64'd1;

  // first of the four field kinds; the others follow in buffer order
  localparam logic [2:0] KIND_SOURCE = 3'd2;

  // Register copies
  logic [31:0] magic_q;
  logic [15:0] version_q;

  // Parser state
  logic [3:0]  phase_q;
  logic [2:0]  count_q;
  logic [63:0] shift_q;
  logic [31:0] remaining_q;
  logic [3:0]  err_q;

  mfd_result_t results_due[$];
  int          fail_total = 0;
  int          due_count  = 0;

  assign mismatches = fail_total;
  assign pending    = due_count;

  task automatic flag_error(input string msg);
    $display("mismatch at %0t ns: %s", $time, msg);
    fail_total++;
  endtask

  // Queue one expected result behind those already due
  task automatic post_result(input mfd_result_t r);
    results_due.insert(results_due.size(), r);
  endtask

  task automatic clear_parse();
    phase_q     = PH_MAGIC;
    count_q     = '0;
    shift_q     = '0;
    remaining_q = '0;
    err_q       = STAT_NONE;
  endtask

  // Shift one byte in; true once n bytes of the word are in
  function automatic bit shift_in_byte(input logic [7:0] b, input int n);
    shift_q = {shift_q[55:0], b};
    if (int'(count_q) >= n - 1) begin
      count_q = '0;
      return 1'b1;
    end
    count_q = count_q + 3'd1;
    return 1'b0;
  endfunction

  // Status the end marker reports from where parsing stopped
  function automatic logic [3:0] closing_status();
    logic [3:0] field_step;
    field_step = phase_q - PH_SRC_LEN;
    if (err_q != STAT_NONE) return err_q;
    if (phase_q == PH_MAGIC) return STAT_MISS_MAGIC;
    if (phase_q == PH_VERSION) return STAT_MISS_VERSION;
    if (phase_q == PH_TYPE) return STAT_MISS_TYPE;
    if (phase_q == PH_ID) return STAT_MISS_ID;
    // a partial length prefix counts against its field
    if (phase_q >= PH_SRC_LEN && phase_q <= PH_PAY_DATA)
      return STAT_BAD_SOURCE + {1'b0, field_step[3:1]};
    return STAT_OK;
  endfunction

  // Advance the parser by one input transaction
  task automatic deframe_step(input logic act, input logic [7:0] b);
    mfd_result_t r;
    logic [3:0]  field_step;
    r          = '0;
    field_step = phase_q - PH_SRC_LEN;
    if (act == ACT_END) begin
      r.kind   = KIND_END;
      r.status = closing_status();
      post_result(r);
      clear_parse();
    end else if (err_q == STAT_NONE && phase_q < PH_DONE) begin
      case (phase_q)
        PH_MAGIC: begin
          if (shift_in_byte(b, 4)) begin
            if (shift_q[31:0] != magic_q) err_q = STAT_BAD_MAGIC;
            else phase_q = PH_VERSION;
            shift_q = '0;
          end
        end
        PH_VERSION: begin
          if (shift_in_byte(b, 2)) begin
            if (shift_q[15:0] != version_q) err_q = STAT_BAD_VERSION;
            else phase_q = PH_TYPE;
            shift_q = '0;
          end
        end
        PH_TYPE: begin
          r.kind  = KIND_TYPE;
          r.value = {56'd0, b};
          post_result(r);
          phase_q = PH_ID;
        end
        PH_ID: begin
          if (shift_in_byte(b, 8)) begin
            r.kind  = KIND_ID;
            r.value = shift_q;
            post_result(r);
            shift_q = '0;
            phase_q = PH_SRC_LEN;
          end
        end
        default: begin
          if (!field_step[0]) begin
            // length prefix; an empty field is skipped
            if (shift_in_byte(b, PREFIX_BYTES)) begin
              remaining_q = 32'(shift_q & PREFIX_MASK);
              shift_q     = '0;
              if (remaining_q != 0) phase_q = phase_q + 4'd1;
              else if (phase_q == PH_PAY_LEN) phase_q = PH_DONE;
              else phase_q = phase_q + 4'd2;
            end
          end else begin
            // field body byte
            remaining_q  = remaining_q - 32'd1;
            r.kind       = KIND_SOURCE + field_step[3:1];
            r.value      = {56'd0, b};
            r.field_last = (remaining_q == 0);
            post_result(r);
            if (r.field_last) phase_q = (phase_q == PH_PAY_DATA) ? PH_DONE : phase_q + 4'd1;
          end
        end
      endcase
    end
  endtask

  // Compare results first, then take config writes and new inputs
  always @(posedge clk) begin
    mfd_result_t due;
    if (rst) begin
      magic_q   = '0;
      version_q = '0;
      clear_parse();
      results_due.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (results_due.size() == 0) begin
          flag_error($sformatf("result kind %0d with nothing due", kind));
        end else begin
          due = results_due.pop_front();
          if (kind !== due.kind)
            flag_error($sformatf("kind %0d, wanted %0d", kind, due.kind));
          if (value !== due.value)
            flag_error($sformatf("value %h, wanted %h", value, due.value));
          if (field_last !== due.field_last)
            flag_error($sformatf("field_last %b, wanted %b", field_last, due.field_last));
          if (status !== due.status)
            flag_error($sformatf("status code %0d, wanted %0d", status, due.status));
        end
      end
      if (cfg_wr_en) begin
        if (cfg_index == REG_MAGIC) magic_q = cfg_data;
        else version_q = cfg_data[15:0];
      end
      if (in_valid && in_ready) deframe_step(action, data_byte);
    end
    due_count = results_due.size();
  end

endmodule

@@ verif/message_frame_deframer_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// message_frame_deframer_test
// Drives message buffers into the deframer: a few short directed buffers,
// then random frames with bad words, empty and oversized fields, trailing
// bytes, truncation and line noise, under several register settings and
// random idling on both channels. The checker beside the block judges.
// ----------------------------------------------------------------------------
module message_frame_deframer_test;
  import mfd_pkg::*;

  localparam int CLK_HALF     = 4;
  localparam int LIMIT_CYCLES = 200000;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES  = 300;
  localparam int PHASES       = 5;
  localparam int PHASE_ITEMS  = 380;

  logic        clk;
  logic        rst;
  logic        cfg_wr_en;
  logic        cfg_index;
  logic [31:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic        action;
  logic [7:0]  data_byte;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  kind;
  logic [63:0] value;
  logic        field_last;
  logic [3:0]  status;
  int          mismatches;
  int          pending;

  bit quiet_send    = 1'b0;
  bit quiet_recv    = 1'b0;
  bit stall_request = 1'b0;
  int cycle_count   = 0;

  message_frame_deframer u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .action    (action),
    .data_byte (data_byte),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .kind      (kind),
    .value     (value),
    .field_last(field_last),
    .status    (status)
  );

  mfd_stream_checker u_check (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .action    (action),
    .data_byte (data_byte),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .kind      (kind),
    .value     (value),
    .field_last(field_last),
    .status    (status),
    .mismatches(mismatches),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Timeout
  initial begin
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("status: fail");
    $finish;
  end

  function automatic bit idle_now(input bit quiet);
    return !quiet && ($urandom_range(99) < 17);
  endfunction

  // Append one byte to a buffer under construction
  function automatic void add_byte(ref logic [7:0] q[$], input logic [7:0] b);
    q.insert(q.size(), b);
  endfunction

  // Receiver: random stalls, plus one long hold-off on request
  initial begin
    int held;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_request) begin
        out_ready <= 1'b0;
        for (held = 0; held < HOLD_CYCLES; held++) @(negedge clk);
        stall_request = 1'b0;
      end else begin
        out_ready <= !idle_now(quiet_recv);
      end
    end
  end

  // One input transaction; called and returns at a falling edge
  task automatic send_item(input logic act, input logic [7:0] b);
    while (idle_now(quiet_send)) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    action    <= act;
    data_byte <= b;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic send_word(input logic [63:0] w, input int nbytes);
    int i;
    for (i = nbytes - 1; i >= 0; i--) send_item(ACT_BYTE, w[8*i +: 8]);
  endtask

  // Let everything due arrive, then give the block time to settle
  task automatic settle_block();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
  endtask

  // Build and send one random buffer closed by an end marker
  task automatic send_frame(input logic [31:0] good_magic, input logic [15:0] good_version,
                            inout int counted);
    logic [7:0]  frame_bytes[$];
    logic [31:0] magic_word;
    logic [15:0] version_word;
    logic [63:0] id_word;
    logic [31:0] field_len;
    int          body_len;
    int          cut;
    int          roll;
    int          f;
    int          i;
    roll         = $urandom_range(99);
    magic_word   = good_magic;
    version_word = good_version;
    if (roll < 5) begin
      // line noise
      repeat ($urandom_range(20)) add_byte(frame_bytes, 8'($urandom));
    end else begin
      if (roll < 11) magic_word = magic_word ^ (32'd1 << $urandom_range(31));
      else if (roll < 17) version_word = version_word ^ (16'd1 << $urandom_range(15));
      id_word = {$urandom, $urandom};
      for (i = 3; i >= 0; i--) add_byte(frame_bytes, magic_word[8*i +: 8]);
      for (i = 1; i >= 0; i--) add_byte(frame_bytes, version_word[8*i +: 8]);
      add_byte(frame_bytes, 8'($urandom));
      for (i = 7; i >= 0; i--) add_byte(frame_bytes, id_word[8*i +: 8]);
      // source, target, event name, payload
      for (f = 0; f < 4; f++) begin
        roll = $urandom_range(99);
        if (roll < 20) field_len = '0;
        else if (roll < 24) field_len = $urandom;
        else field_len = $urandom_range(1, 8);
        for (i = 3; i >= 0; i--) add_byte(frame_bytes, field_len[8*i +: 8]);
        // an oversized field only gets a few bytes before the buffer runs out
        body_len = (field_len > 12) ? $urandom_range(6) : int'(field_len);
        repeat (body_len) add_byte(frame_bytes, 8'($urandom));
      end
      // trailing bytes after the payload
      if ($urandom_range(99) < 25)
        repeat ($urandom_range(1, 3)) add_byte(frame_bytes, 8'($urandom));
    end
    // truncated buffer
    if (frame_bytes.size() > 0 && $urandom_range(99) < 15) begin
      cut = $urandom_range(frame_bytes.size() - 1);
      while (frame_bytes.size() > cut) void'(frame_bytes.pop_back());
    end
    foreach (frame_bytes[k]) send_item(ACT_BYTE, frame_bytes[k]);
    send_item(ACT_END, 8'($urandom));
    counted += frame_bytes.size() + 1;
  endtask

  // Stimulus
  initial begin
    logic [31:0] magic_set;
    logic [15:0] version_set;
    int          phase_items;
    int          ph;
    rst       = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_index = REG_MAGIC;
    cfg_data  = '0;
    in_valid  = 1'b0;
    action    = ACT_BYTE;
    data_byte = '0;
    repeat (3) @(negedge clk);
    rst <= 1'b0;

    for (ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin
          magic_set   = '1;
          version_set = '1;
        end
        1: begin
          magic_set   = '0;
          version_set = '0;
        end
        default: begin
          magic_set   = $urandom;
          version_set = 16'($urandom);
        end
      endcase
      settle_block();
      write_reg(REG_MAGIC, magic_set);
      write_reg(REG_VERSION, {16'd0, version_set});
      cfg_wr_en <= 1'b0;
      phase_items = 0;

      if (ph == 0) begin
        // end marker on an empty buffer
        send_item(ACT_END, 8'hFF);
        // wrong magic, the byte after it is ignored
        send_word(64'd0, 4);
        send_item(ACT_BYTE, 8'hFF);
        send_item(ACT_END, 8'h00);
        // wrong version
        send_word({32'd0, magic_set}, 4);
        send_word(64'd0, 2);
        send_item(ACT_END, 8'h00);
        // buffer stops after the magic
        send_word({32'd0, magic_set}, 4);
        send_item(ACT_END, 8'h00);
        // buffer stops after the type byte
        send_word({32'd0, magic_set}, 4);
        send_word({48'd0, version_set}, 2);
        send_item(ACT_BYTE, 8'hFF);
        send_item(ACT_END, 8'h5A);
        phase_items = 27;
      end
      // one phase runs with no idling on either side
      quiet_send = (ph == 1);
      quiet_recv = (ph == 1);
      // one long receiver hold-off while frames keep coming
      if (ph == 2) stall_request = 1'b1;

      while (phase_items < PHASE_ITEMS) send_frame(magic_set, version_set, phase_items);
    end

    settle_block();
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ files.f @@
design/mfd_pkg.sv
design/mfd_cfg_regs.sv
design/mfd_parser.sv
design/mfd_out_buf.sv
design/message_frame_deframer.sv
verif/mfd_stream_checker.sv
verif/message_frame_deframer_test.sv
